[rtl/dcc_pkg.sv]
// Package for the accessory packet decoder: codes, types and constants.
// No dependencies.
`default_nettype none
package dcc_pkg;
  localparam int unsigned MaxPacketBytes = 6;
  localparam int unsigned BufBytes = 8;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0, EV_TURNOUT = 2'd1, EV_CHECKSUM = 2'd2, EV_TIMING = 2'd3
  } event_e;

  typedef enum logic [3:0] {
    PH_PREAMBLE = 4'b0001, PH_START = 4'b0010, PH_NEXT = 4'b0100, PH_BYTE = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    PW_NONE = 2'd0, PW_120 = 2'd1, PW_121 = 2'd2
  } pend_e;

  typedef enum logic [2:0] {
    REG_ONE_THR = 3'd0, REG_MAX_INT = 3'd1, REG_PRE_MIN = 3'd2,
    REG_RST_SVC = 3'd3, REG_ACK = 3'd4, REG_SVC_TO = 3'd5
  } reg_e;

  // configuration as seen by the packet engine
  typedef struct packed {
    logic [15:0] one_threshold;
    logic [15:0] max_interval;
    logic [7:0]  preamble_min;
    logic [7:0]  resets_for_service;
    logic [15:0] ack_ticks;
    logic [15:0] service_timeout_ticks;
  } cfg_t;

  localparam logic [16:0] ElapsedCap = 17'h10000;
endpackage
`default_nettype wire

[rtl/dcc_regs.sv]
// APB register file for the decoder thresholds and timeouts.
// Depends on dcc_pkg.
`default_nettype none
module dcc_regs import dcc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);
  cfg_t cfg_q;
  logic wr;
  logic [2:0] idx;
  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign idx = paddr[4:2];
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_threshold <= 16'd870;
      cfg_q.max_interval <= 16'd1450;
      cfg_q.preamble_min <= 8'd10;
      cfg_q.resets_for_service <= 8'd25;
      cfg_q.ack_ticks <= 16'd24;
      cfg_q.service_timeout_ticks <= 16'd122;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (idx)
        REG_ONE_THR: cfg_q.one_threshold <= pwdata[15:0];
        REG_MAX_INT: cfg_q.max_interval <= pwdata[15:0];
        REG_PRE_MIN: cfg_q.preamble_min <= pwdata[7:0];
        REG_RST_SVC: cfg_q.resets_for_service <= pwdata[7:0];
        REG_ACK:     cfg_q.ack_ticks <= pwdata[15:0];
        REG_SVC_TO:  cfg_q.service_timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ONE_THR: prdata = {16'd0, cfg_q.one_threshold};
      REG_MAX_INT: prdata = {16'd0, cfg_q.max_interval};
      REG_PRE_MIN: prdata = {24'd0, cfg_q.preamble_min};
      REG_RST_SVC: prdata = {24'd0, cfg_q.resets_for_service};
      REG_ACK:     prdata = {16'd0, cfg_q.ack_ticks};
      REG_SVC_TO:  prdata = {16'd0, cfg_q.service_timeout_ticks};
      default:     prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

[rtl/dcc_accessory_packet_decoder.sv]
// Top level of the accessory packet decoder: input register, packet engine
// and result register. Depends on dcc_pkg and dcc_regs.
//
//   channel | handshake          | payload
//   in      | in_valid_i/stall_o | operation_i, interval_i
//   out     | out_valid_o/stall_i| event_res_o ... decoder_address_o
//   cfg     | APB psel/penable   | paddr, pwdata, prdata
//
// One item per cycle while the output is not stalled: a request is
// registered, decoded by one pass of combinational logic and then lands
// in the result register. Reset restores the control and decoder state
// and the register file to their power-on values at once; the input data
// and result registers are not reset. A stalled result holds the result
// register, and the input side stalls only while both stages are full.
`default_nettype none
module dcc_accessory_packet_decoder import dcc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [15:0] interval_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       event_res_o,
  output logic             turnout_position_o,
  output logic             ack_active_o,
  output logic             service_active_o,
  output logic [15:0]      decoder_address_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  cfg_t cfg;
  dcc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // input stage
  logic in_v_q, op_q;
  logic [15:0] iv_q;
  logic out_v_q;
  logic adv;
  assign adv = in_v_q && !(out_v_q && out_stall_i);
  assign in_stall_o = in_v_q && !adv;

  // decoder state
  phase_e ph_q, ph_d;
  logic [7:0] pre_q, pre_d;
  logic [7:0] pb_q [BufBytes];
  logic [7:0] pb_d [BufBytes];
  logic [2:0] bc_q, bc_d, bp_q, bp_d;
  logic [7:0] ah_q, ah_d, al_q, al_d, dcb_q, dcb_d;
  logic svc_q, svc_d, ackon_q, ackon_d;
  logic [7:0] rpc_q, rpc_d, orc_q, orc_d, pav_q, pav_d;
  pend_e paw_q, paw_d;
  logic [16:0] acke_q, acke_d, svce_q, svce_d;
  logic [1:0] ev;
  logic pos;

  // result registers
  logic [1:0] ev_q;
  logic pos_q, ack_o_q, svc_o_q;
  logic [15:0] addr_o_q;

  logic bit_v, ops, rst, basic, ext;
  logic [7:0] x, b0, b1, b2, cb0, cb1, cb2, val, reg_v;
  logic [1:0] kind;
  logic [10:0] cvnum;
  logic bwrite;
  logic [2:0] bpos;
  logic [15:0] addr_b, addr_e, cur;
  logic [9:0] modv;

  // CV access on latched bytes (service layout in service mode, else ops)
  always_comb begin
    b0 = pb_q[0]; b1 = pb_q[1]; b2 = pb_q[2];
    cb0 = svc_q ? pb_q[0] : pb_q[2];
    cb1 = svc_q ? pb_q[1] : pb_q[3];
    cb2 = svc_q ? pb_q[2] : pb_q[4];
    kind = cb0[3:2];
    cvnum = {1'b0, cb0[1:0], cb1} + 11'd1;
    bwrite = (kind == 2'd2) && cb2[4];
    bpos = (kind == 2'd2) ? cb2[2:0] : 3'd0;
    val = (kind == 2'd2) ? {7'd0, cb2[3]} : cb2;
    reg_v = (cvnum == 11'd121) ? al_q : ah_q;
    x = '0;
    for (int i = 0; i < BufBytes; i++) begin
      if (3'(i) < bc_q) x = x ^ pb_q[i];
    end
    cur = {ah_q, al_q};
    modv = {1'b0, ~b1[6:4], b0[5:0]} ;
    addr_b = 16'((({6'd0, modv} + 16'hffff) << 2) + {14'd0, b1[2:1]} + 16'd1);
    addr_e = {8'd0, b0[5:0], 2'd0} | {5'd0, ~b1[6:4], 8'd0} | {14'd0, b1[2:1]};
    basic = b0[7:6] == 2'b10 && b1[7];
    ext = b0[7:6] == 2'b10 && !b1[7] && (b1 & 8'h89) == 8'h01;
    ops = bc_q == 3'd6 && b2[7:4] == 4'he &&
          ((basic && (b1 & 8'h89) == 8'h88) || (ext && (b1 & 8'h89) == 8'h01));
    rst = bc_q == 3'd3 && b0 == 8'd0 && b1 == 8'd0;
  end

  always_comb begin
    ph_d = ph_q; pre_d = pre_q; bc_d = bc_q; bp_d = bp_q;
    for (int i = 0; i < BufBytes; i++) pb_d[i] = pb_q[i];
    ah_d = ah_q; al_d = al_q; dcb_d = dcb_q; svc_d = svc_q; ackon_d = ackon_q;
    rpc_d = rpc_q; orc_d = orc_q; pav_d = pav_q; paw_d = paw_q;
    acke_d = acke_q; svce_d = svce_q;
    ev = EV_NONE; pos = 1'b0;
    bit_v = iv_q < cfg.one_threshold;
    if (op_q) begin
      if (ackon_q && acke_q < ElapsedCap) acke_d = acke_q + 17'd1;
      if (svc_q && svce_q < ElapsedCap) svce_d = svce_q + 17'd1;
    end else if (iv_q > cfg.max_interval) begin
      ph_d = PH_PREAMBLE; pre_d = '0; ev = EV_TIMING;
    end else begin
      case (ph_q)
        PH_PREAMBLE: begin
          if (bit_v) begin
            if (pre_q != 8'hff) pre_d = pre_q + 8'd1;
          end else pre_d = '0;
          if (pre_d >= cfg.preamble_min) ph_d = PH_START;
        end
        PH_START: if (!bit_v) begin
          ph_d = PH_BYTE; bp_d = 3'd7; pre_d = '0; bc_d = '0;
          for (int i = 0; i < BufBytes; i++) pb_d[i] = '0;
        end
        PH_NEXT: begin
          if (!bit_v) begin
            if (bc_q >= 3'(MaxPacketBytes)) begin
              ph_d = PH_PREAMBLE; pre_d = '0;
            end else begin
              ph_d = PH_BYTE; bp_d = 3'd7;
            end
          end else begin
            ph_d = PH_PREAMBLE;
            if (x != 8'd0) ev = EV_CHECKSUM;
            else begin
              if (!rst) rpc_d = '0;
              if (!ops) begin
                orc_d = '0; paw_d = PW_NONE;
              end
              if (rst) begin
                if (!svc_q) begin
                  if (rpc_q != 8'hff) rpc_d = rpc_q + 8'd1;
                  if (rpc_d >= cfg.resets_for_service) begin
                    rpc_d = '0; svc_d = 1'b1; svce_d = '0;
                  end
                end else svce_d = '0;
              end else if (svc_q || ((basic && !dcb_q[5] && addr_b == cur) ||
                                     (!basic && ext && dcb_q[5] && addr_e == cur))) begin
                if (!svc_q && !ops) begin
                  ev = EV_TURNOUT; pos = basic ? b1[0] : b2[0];
                end
                if (!svc_q && ops && orc_q == 8'd0) orc_d = pb_q[5];
                else if (svc_q || (ops && orc_q == pb_q[5])) begin
                  // CV access
                  if ((svc_q && cb0[7:4] == 4'h7) || (!svc_q && b2[7:4] == 4'he)) begin
                    if (cvnum == 11'd120 || cvnum == 11'd121) begin
                      if (kind == 2'd1) begin
                        if (svc_q && reg_v == val) begin ackon_d = 1'b1; acke_d = '0; end
                      end else if (kind == 2'd3) begin
                        if (svc_q) begin
                          if (cvnum == 11'd121) al_d = val; else ah_d = val;
                          ackon_d = 1'b1; acke_d = '0;
                        end
                        if (!svc_q && ((paw_q == PW_121 && cvnum == 11'd120) ||
                                       (paw_q == PW_120 && cvnum == 11'd121))) begin
                          al_d = (cvnum == 11'd121) ? val : pav_q;
                          ah_d = (cvnum == 11'd120) ? val : pav_q;
                          pav_d = '0; paw_d = PW_NONE;
                        end else begin
                          orc_d = '0; pav_d = val;
                          paw_d = (cvnum == 11'd120) ? PW_120 : PW_121;
                        end
                      end
                    end else if (cvnum == 11'd29) begin
                      if (kind == 2'd1) begin
                        if (svc_q && dcb_q == val) begin ackon_d = 1'b1; acke_d = '0; end
                      end else if (kind == 2'd3) begin
                        dcb_d = val;
                        if (svc_q) begin ackon_d = 1'b1; acke_d = '0; end
                      end else if (kind == 2'd2) begin
                        if (bwrite) begin
                          dcb_d[bpos] = val[0];
                          if (svc_q) begin ackon_d = 1'b1; acke_d = '0; end
                        end else if (svc_q && val[0] == dcb_q[bpos]) begin
                          ackon_d = 1'b1; acke_d = '0;
                        end
                      end
                    end
                  end
                end
              end
            end
          end
        end
        PH_BYTE: begin
          pb_d[bc_q][bp_q] = pb_q[bc_q][bp_q] | bit_v;
          if (bp_q == 3'd0) begin
            ph_d = PH_NEXT; bc_d = bc_q + 3'd1;
          end else bp_d = bp_q - 3'd1;
        end
        default: ph_d = PH_PREAMBLE;
      endcase
    end
    if (ackon_d && acke_d > {1'b0, cfg.ack_ticks}) ackon_d = 1'b0;
    if (svc_d && svce_d > {1'b0, cfg.service_timeout_ticks}) svc_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0; out_v_q <= 1'b0;
      ph_q <= PH_PREAMBLE; pre_q <= '0; bc_q <= '0; bp_q <= '0;
      for (int i = 0; i < BufBytes; i++) pb_q[i] <= '0;
      ah_q <= 8'h01; al_q <= 8'h05; dcb_q <= 8'h80; svc_q <= 1'b0;
      rpc_q <= '0; orc_q <= '0; pav_q <= '0; paw_q <= PW_NONE;
      ackon_q <= 1'b0; acke_q <= '0; svce_q <= '0;
    end else begin
      if (!in_stall_o) in_v_q <= in_valid_i;
      if (adv) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
      if (adv) begin
        ph_q <= ph_d; pre_q <= pre_d; bc_q <= bc_d; bp_q <= bp_d;
        for (int i = 0; i < BufBytes; i++) pb_q[i] <= pb_d[i];
        ah_q <= ah_d; al_q <= al_d; dcb_q <= dcb_d; svc_q <= svc_d;
        rpc_q <= rpc_d; orc_q <= orc_d; pav_q <= pav_d; paw_q <= paw_d;
        ackon_q <= ackon_d; acke_q <= acke_d; svce_q <= svce_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      op_q <= operation_i; iv_q <= interval_i;
    end
    if (adv) begin
      ev_q <= ev; pos_q <= pos; ack_o_q <= ackon_d; svc_o_q <= svc_d;
      addr_o_q <= {ah_d, al_d};
    end
  end

  assign out_valid_o = out_v_q;
  assign event_res_o = ev_q;
  assign turnout_position_o = pos_q;
  assign ack_active_o = ack_o_q;
  assign service_active_o = svc_o_q;
  assign decoder_address_o = addr_o_q;

`ifndef SYNTH
  a_pos_only_turnout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && turnout_position_o |-> event_res_o == EV_TURNOUT) else $error("pos");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i) else $error("stall");
  a_bc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= 3'(MaxPacketBytes)) else $error("bc");
`endif
endmodule
`default_nettype wire
